// File: hw/rtl/rti_pkg.sv
// shared types, constants and arithmetic helpers of the ray/triangle intersection unit
`timescale 1ns / 1ps
package rti_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int VERTEX_COUNT     = 1024;
  localparam int TRIANGLE_COUNT   = 1024;
  localparam int WORDS_PER_VERTEX = 8;
  localparam int CORNERS          = 3;
  localparam int VIDX_W           = $clog2(VERTEX_COUNT);
  localparam int TIDX_W           = $clog2(TRIANGLE_COUNT);
  localparam int NEAR_BOUND       = ((1 << FRAC_BITS) + 50) / 100;

  localparam int DIV_NW  = 66;
  localparam int DIV_DW  = 34;
  localparam int DIV_QW  = 34;
  localparam int DIV_LAT = DIV_QW + 1;

  localparam int NST = 14;

  localparam logic [1:0] REQ_VERTEX = 2'd0;
  localparam logic [1:0] REQ_CORNER = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  typedef logic signed [31:0] q_t;
  typedef logic signed [47:0] prod_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  item_index;
    logic [2:0]  word_select;
    q_t          load_value;
    q_t          ray_org_x;
    q_t          ray_org_y;
    q_t          ray_org_z;
    q_t          ray_dir_x;
    q_t          ray_dir_y;
    q_t          ray_dir_z;
    logic [30:0] ray_limit;
  } rti_in_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] hit_dist;
    q_t          hit_pos_x;
    q_t          hit_pos_y;
    q_t          hit_pos_z;
    q_t          surf_norm_x;
    q_t          surf_norm_y;
    q_t          surf_norm_z;
    q_t          tex_u;
    q_t          tex_v;
    logic        faces_front;
  } rti_out_t;

  typedef struct {
    q_t                 org [0:2];
    q_t                 dir [0:2];
    logic [30:0]        limit;
    logic               miss;
    logic [1:0]         major;
    q_t                 word [0:2][0:7];
    q_t                 dz;
    q_t                 dia;
    q_t                 dib;
    q_t                 qz [0:2];
    q_t                 ra [0:2];
    q_t                 rb [0:2];
    q_t                 shx;
    q_t                 shy;
    q_t                 scz;
    prod_t              pa [0:2];
    prod_t              pb [0:2];
    prod_t              pc [0:2];
    q_t                 qx [0:2];
    q_t                 qy [0:2];
    q_t                 sz [0:2];
    q_t                 edge_fn [0:2];
    logic signed [33:0] den;
    logic signed [49:0] ts;
    logic [48:0]        bound;
    q_t                 bary [0:2];
    logic [30:0]        tq;
    prod_t              bp [0:2][0:7];
    q_t                 blend [0:7];
    prod_t              dp [0:2];
  } rti_work_t;

  function automatic q_t sat32(logic signed [67:0] x);
    if (x > 68'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -68'sd2147483648) return 32'sh80000000;
    return 32'(x);
  endfunction

  // product rounded half up to FRAC_BITS fraction bits
  function automatic prod_t qmul(q_t a, q_t b);
    logic signed [64:0] p;
    p = 65'(a) * 65'(b) + (65'sd1 <<< (FRAC_BITS - 1));
    return 48'(p >>> FRAC_BITS);
  endfunction

  function automatic logic [31:0] mag32(q_t x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  function automatic q_t sdiv_fix(logic [DIV_QW:0] q, logic neg);
    logic signed [DIV_QW+1:0] v;
    v = $signed({1'b0, q});
    if (neg) v = -v;
    return sat32(68'(v));
  endfunction

endpackage

// File: hw/rtl/rti_ram.sv
// generic single-port-write ram with registered read (read-first)
`timescale 1ns / 1ps
module rti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/rti_div.sv
// pipelined restoring divider, one quotient bit per stage, round half away from zero
`timescale 1ns / 1ps
module rti_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rti_pkg::DIV_NW-1:0] num_i,
  input  logic [rti_pkg::DIV_DW-1:0] den_i,
  output logic [rti_pkg::DIV_QW:0]   quot_o
);
  import rti_pkg::*;

  logic [DIV_DW-1:0] rem_r [0:DIV_QW];
  logic [DIV_QW-1:0] low_r [0:DIV_QW-1];
  logic [DIV_QW-1:0] quo_r [0:DIV_QW];
  logic [DIV_DW-1:0] den_r [0:DIV_QW];
  logic [DIV_DW:0]   trial [1:DIV_QW];
  logic              rnd;

  always_comb begin
    for (int i = 1; i <= DIV_QW; i++) begin
      trial[i] = {rem_r[i-1], low_r[i-1][DIV_QW-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DIV_DW'(num_i[DIV_NW-1:DIV_QW]);
      low_r[0] <= num_i[DIV_QW-1:0];
      quo_r[0] <= '0;
      den_r[0] <= den_i;
      for (int i = 1; i <= DIV_QW; i++) begin
        if (trial[i] >= {1'b0, den_r[i-1]}) begin
          rem_r[i] <= DIV_DW'(trial[i] - {1'b0, den_r[i-1]});
          quo_r[i] <= {quo_r[i-1][DIV_QW-2:0], 1'b1};
        end else begin
          rem_r[i] <= trial[i][DIV_DW-1:0];
          quo_r[i] <= {quo_r[i-1][DIV_QW-2:0], 1'b0};
        end
        if (i < DIV_QW) low_r[i] <= {low_r[i-1][DIV_QW-2:0], 1'b0};
        den_r[i] <= den_r[i-1];
      end
    end
  end

  assign rnd    = {rem_r[DIV_QW], 1'b0} >= {1'b0, den_r[DIV_QW]};
  assign quot_o = {1'b0, quo_r[DIV_QW]} + (DIV_QW + 1)'(rnd);

endmodule

// File: hw/rtl/ray_triangle_intersect_unit.sv
// top level of the watertight ray/triangle intersection unit
`timescale 1ns / 1ps
// Takes one request per cycle while input is not held off: vertex word writes,
// corner index writes and ray queries share the input channel, and only queries
// return a result. A query reads its three corner indices, then all 24 vertex
// words of the triangle at once from replicated vertex rams, and runs through
// the pipeline stages to the output buffer; the two banks of pipelined dividers
// (shear factors, then barycentrics and t) lie between those stages. A write is
// visible to any query accepted after it. The stores come up undefined; no
// clearing pass runs after reset. A two-entry output buffer lets requests keep
// flowing while a result waits to be taken; input is held off only when that
// buffer is full. On a miss all result fields are zero.
module ray_triangle_intersect_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rti_pkg::rti_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rti_pkg::rti_out_t out_data
);
  import rti_pkg::*;

  logic adv, in_fire, tri_ok, vtx_ok, push, pop;
  logic [1:0] cnt_r;
  rti_out_t ent0_r, ent1_r, res;

  logic [VIDX_W-1:0] corner_q [0:CORNERS-1];
  q_t vword_q [0:CORNERS-1][0:WORDS_PER_VERTEX-1];

  rti_work_t s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s7_r, s8_r, s9_r, s10_r;
  rti_work_t s11_r, s12_r, s13_r, s14_r;
  rti_work_t s1_nxt, s2_nxt, s3_nxt, s4_nxt, s5_nxt, s6_nxt, s7_nxt, s8_nxt;
  rti_work_t s9_nxt, s10_nxt, s10_chk, s11_nxt, s12_nxt, s13_nxt, s14_nxt;
  rti_work_t dla_r [0:DIV_LAT-1];
  rti_work_t dlb_r [0:DIV_LAT-1];
  logic [NST:1] sv_r;
  logic [DIV_LAT-1:0] dla_vld_r, dlb_vld_r;

  logic [31:0] am [0:2];
  q_t rel [0:2][0:2];
  logic [1:0] ax_z, ax_a, ax_b;
  logic [33:0] den_mag9, den_mag10;
  logic [49:0] ts_mag;
  logic anyneg, anypos, rng_miss;
  logic signed [49:0] dot;

  logic [DIV_NW-1:0] dva_num [0:2];
  logic [DIV_QW:0]   dva_q [0:2];
  logic [DIV_DW-1:0] dva_den;
  logic [DIV_NW-1:0] dvb_num [0:3];
  logic [DIV_QW:0]   dvb_q [0:3];
  logic [DIV_DW-1:0] dvb_den;

  assign adv      = (cnt_r != 2'd2);
  assign in_ready = adv;
  assign in_fire  = in_valid && in_ready;
  assign tri_ok   = 32'(in_data.item_index) < 32'(TRIANGLE_COUNT);
  assign vtx_ok   = 32'(in_data.item_index) < 32'(VERTEX_COUNT);

  // corner and vertex stores
  for (genvar k = 0; k < CORNERS; k++) begin : g_corner
    rti_ram #(.WIDTH(VIDX_W), .DEPTH(TRIANGLE_COUNT)) u_corner_ram (
      .clk   (clk),
      .we    (in_fire && in_data.req_type == REQ_CORNER && tri_ok &&
              in_data.word_select == 3'(k) &&
              $unsigned(in_data.load_value) < 32'(VERTEX_COUNT)),
      .waddr (TIDX_W'(in_data.item_index)),
      .wdata (VIDX_W'(in_data.load_value)),
      .re    (adv),
      .raddr (TIDX_W'(in_data.item_index)),
      .rdata (corner_q[k])
    );
    for (genvar w = 0; w < WORDS_PER_VERTEX; w++) begin : g_word
      rti_ram #(.WIDTH(32), .DEPTH(VERTEX_COUNT)) u_vertex_ram (
        .clk   (clk),
        .we    (in_fire && in_data.req_type == REQ_VERTEX && vtx_ok &&
                in_data.word_select == 3'(w)),
        .waddr (VIDX_W'(in_data.item_index)),
        .wdata (in_data.load_value),
        .re    (adv),
        .raddr (corner_q[k]),
        .rdata (vword_q[k][w])
      );
    end
  end

  // shear and scale dividers
  assign dva_num[0] = DIV_NW'(mag32(s3_r.dia)) << FRAC_BITS;
  assign dva_num[1] = DIV_NW'(mag32(s3_r.dib)) << FRAC_BITS;
  assign dva_num[2] = DIV_NW'(1) << (2 * FRAC_BITS);
  assign dva_den    = DIV_DW'(mag32(s3_r.dz));

  for (genvar i = 0; i < 3; i++) begin : g_dva
    rti_div u_div (.clk(clk), .en(adv), .num_i(dva_num[i]), .den_i(dva_den),
                   .quot_o(dva_q[i]));
  end

  // barycentric and distance dividers
  assign den_mag10 = s10_r.den[33] ? 34'(-s10_r.den) : 34'(s10_r.den);
  assign ts_mag    = s10_r.ts[49] ? 50'(-s10_r.ts) : 50'(s10_r.ts);
  assign dvb_num[0] = DIV_NW'(mag32(s10_r.edge_fn[0])) << FRAC_BITS;
  assign dvb_num[1] = DIV_NW'(mag32(s10_r.edge_fn[1])) << FRAC_BITS;
  assign dvb_num[2] = DIV_NW'(mag32(s10_r.edge_fn[2])) << FRAC_BITS;
  assign dvb_num[3] = DIV_NW'(ts_mag) << FRAC_BITS;
  assign dvb_den    = DIV_DW'(den_mag10);

  for (genvar i = 0; i < 4; i++) begin : g_dvb
    rti_div u_div (.clk(clk), .en(adv), .num_i(dvb_num[i]), .den_i(dvb_den),
                   .quot_o(dvb_q[i]));
  end

  always_comb begin
    s1_nxt = s1_r;
    s1_nxt.org[0] = in_data.ray_org_x;
    s1_nxt.org[1] = in_data.ray_org_y;
    s1_nxt.org[2] = in_data.ray_org_z;
    s1_nxt.dir[0] = in_data.ray_dir_x;
    s1_nxt.dir[1] = in_data.ray_dir_y;
    s1_nxt.dir[2] = in_data.ray_dir_z;
    s1_nxt.limit  = in_data.ray_limit;
    s1_nxt.miss   = !tri_ok;

    // major axis of the direction
    s2_nxt = s1_r;
    for (int a = 0; a < 3; a++) am[a] = mag32(s1_r.dir[a]);
    if (am[0] > am[1]) s2_nxt.major = (am[0] > am[2]) ? 2'd0 : 2'd2;
    else               s2_nxt.major = (am[1] > am[2]) ? 2'd1 : 2'd2;

    // translate and permute
    s3_nxt = s2_r;
    case (s2_r.major)
      2'd0: begin
        ax_z = 2'd0; ax_a = 2'd1; ax_b = 2'd2;
      end
      2'd1: begin
        ax_z = 2'd1; ax_a = 2'd2; ax_b = 2'd0;
      end
      default: begin
        ax_z = 2'd2; ax_a = 2'd0; ax_b = 2'd1;
      end
    endcase
    for (int k = 0; k < 3; k++) begin
      for (int w = 0; w < 8; w++) s3_nxt.word[k][w] = vword_q[k][w];
      for (int a = 0; a < 3; a++) rel[k][a] = sat32(68'(vword_q[k][a]) - 68'(s2_r.org[a]));
      s3_nxt.qz[k] = rel[k][ax_z];
      s3_nxt.ra[k] = rel[k][ax_a];
      s3_nxt.rb[k] = rel[k][ax_b];
    end
    s3_nxt.dz   = s2_r.dir[ax_z];
    s3_nxt.dia  = s2_r.dir[ax_a];
    s3_nxt.dib  = s2_r.dir[ax_b];
    s3_nxt.miss = s2_r.miss || (s2_r.dir[ax_z] == 0);

    s4_nxt = dla_r[DIV_LAT-1];
    s4_nxt.shx = sdiv_fix(dva_q[0], (dla_r[DIV_LAT-1].dia > 0) != (dla_r[DIV_LAT-1].dz < 0));
    s4_nxt.shy = sdiv_fix(dva_q[1], (dla_r[DIV_LAT-1].dib > 0) != (dla_r[DIV_LAT-1].dz < 0));
    s4_nxt.scz = sdiv_fix(dva_q[2], dla_r[DIV_LAT-1].dz < 0);

    s5_nxt = s4_r;
    for (int k = 0; k < 3; k++) begin
      s5_nxt.pa[k] = qmul(s4_r.shx, s4_r.qz[k]);
      s5_nxt.pb[k] = qmul(s4_r.shy, s4_r.qz[k]);
      s5_nxt.pc[k] = qmul(s4_r.qz[k], s4_r.scz);
    end

    s6_nxt = s5_r;
    for (int k = 0; k < 3; k++) begin
      s6_nxt.qx[k] = sat32(68'(s5_r.ra[k]) + 68'(s5_r.pa[k]));
      s6_nxt.qy[k] = sat32(68'(s5_r.rb[k]) + 68'(s5_r.pb[k]));
      s6_nxt.sz[k] = sat32(68'(s5_r.pc[k]));
    end

    s7_nxt = s6_r;
    s7_nxt.pa[0] = qmul(s6_r.qx[1], s6_r.qy[2]);
    s7_nxt.pb[0] = qmul(s6_r.qy[1], s6_r.qx[2]);
    s7_nxt.pa[1] = qmul(s6_r.qx[2], s6_r.qy[0]);
    s7_nxt.pb[1] = qmul(s6_r.qy[2], s6_r.qx[0]);
    s7_nxt.pa[2] = qmul(s6_r.qx[0], s6_r.qy[1]);
    s7_nxt.pb[2] = qmul(s6_r.qy[0], s6_r.qx[1]);

    s8_nxt = s7_r;
    for (int k = 0; k < 3; k++) s8_nxt.edge_fn[k] = sat32(68'(s7_r.pa[k]) - 68'(s7_r.pb[k]));

    // edge sign test, determinant, distance terms
    s9_nxt = s8_r;
    anyneg = s8_r.edge_fn[0] < 0 || s8_r.edge_fn[1] < 0 || s8_r.edge_fn[2] < 0;
    anypos = s8_r.edge_fn[0] > 0 || s8_r.edge_fn[1] > 0 || s8_r.edge_fn[2] > 0;
    for (int k = 0; k < 3; k++) s9_nxt.pc[k] = qmul(s8_r.edge_fn[k], s8_r.sz[k]);
    s9_nxt.den  = 34'(s8_r.edge_fn[0]) + 34'(s8_r.edge_fn[1]) + 34'(s8_r.edge_fn[2]);
    s9_nxt.miss = s8_r.miss || (anyneg && anypos);

    s10_nxt = s9_r;
    den_mag9 = s9_r.den[33] ? 34'(-s9_r.den) : 34'(s9_r.den);
    s10_nxt.ts    = 50'(s9_r.pc[0]) + 50'(s9_r.pc[1]) + 50'(s9_r.pc[2]);
    s10_nxt.bound = 49'((65'(s9_r.limit) * 65'(den_mag9)) >> FRAC_BITS);
    s10_nxt.miss  = s9_r.miss || (s9_r.den == 0);

    // range test
    s10_chk = s10_r;
    if (s10_r.den > 0) rng_miss = (s10_r.ts <= 50'(NEAR_BOUND)) || (ts_mag > 50'(s10_r.bound));
    else               rng_miss = (s10_r.ts >= 0) || (ts_mag > 50'(s10_r.bound));
    s10_chk.miss = s10_r.miss || rng_miss;

    s11_nxt = dlb_r[DIV_LAT-1];
    for (int k = 0; k < 3; k++) begin
      s11_nxt.bary[k] = sdiv_fix(dvb_q[k],
                                 (dlb_r[DIV_LAT-1].edge_fn[k] < 0) != (dlb_r[DIV_LAT-1].den < 0));
    end
    if ((dlb_r[DIV_LAT-1].ts < 0) != (dlb_r[DIV_LAT-1].den < 0)) s11_nxt.tq = '0;
    else if (dvb_q[3] > (DIV_QW + 1)'(31'h7FFFFFFF))             s11_nxt.tq = 31'h7FFFFFFF;
    else                                                         s11_nxt.tq = dvb_q[3][30:0];

    s12_nxt = s11_r;
    for (int k = 0; k < 3; k++) begin
      for (int w = 0; w < 8; w++) s12_nxt.bp[k][w] = qmul(s11_r.bary[k], s11_r.word[k][w]);
    end

    s13_nxt = s12_r;
    for (int w = 0; w < 8; w++) begin
      s13_nxt.blend[w] = sat32(68'(s12_r.bp[0][w]) + 68'(s12_r.bp[1][w]) + 68'(s12_r.bp[2][w]));
    end

    s14_nxt = s13_r;
    for (int a = 0; a < 3; a++) s14_nxt.dp[a] = qmul(s13_r.dir[a], s13_r.blend[3+a]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      dla_r[0] <= s3_r;
      for (int i = 1; i < DIV_LAT; i++) dla_r[i] <= dla_r[i-1];
      s4_r  <= s4_nxt;
      s5_r  <= s5_nxt;
      s6_r  <= s6_nxt;
      s7_r  <= s7_nxt;
      s8_r  <= s8_nxt;
      s9_r  <= s9_nxt;
      s10_r <= s10_nxt;
      dlb_r[0] <= s10_chk;
      for (int i = 1; i < DIV_LAT; i++) dlb_r[i] <= dlb_r[i-1];
      s11_r <= s11_nxt;
      s12_r <= s12_nxt;
      s13_r <= s13_nxt;
      s14_r <= s14_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r      <= '0;
      dla_vld_r <= '0;
      dlb_vld_r <= '0;
    end else if (adv) begin
      sv_r[1]   <= in_fire && in_data.req_type == REQ_QUERY;
      sv_r[2]   <= sv_r[1];
      sv_r[3]   <= sv_r[2];
      dla_vld_r <= {dla_vld_r[DIV_LAT-2:0], sv_r[3]};
      sv_r[4]   <= dla_vld_r[DIV_LAT-1];
      for (int i = 5; i <= 10; i++) sv_r[i] <= sv_r[i-1];
      dlb_vld_r <= {dlb_vld_r[DIV_LAT-2:0], sv_r[10]};
      sv_r[11]  <= dlb_vld_r[DIV_LAT-1];
      for (int i = 12; i <= NST; i++) sv_r[i] <= sv_r[i-1];
    end
  end

  // result assembly
  always_comb begin
    dot = 50'(s14_r.dp[0]) + 50'(s14_r.dp[1]) + 50'(s14_r.dp[2]);
    res = '0;
    if (!s14_r.miss) begin
      res.hit         = 1'b1;
      res.hit_dist    = s14_r.tq;
      res.hit_pos_x   = s14_r.blend[0];
      res.hit_pos_y   = s14_r.blend[1];
      res.hit_pos_z   = s14_r.blend[2];
      res.surf_norm_x = s14_r.blend[3];
      res.surf_norm_y = s14_r.blend[4];
      res.surf_norm_z = s14_r.blend[5];
      res.tex_u       = s14_r.blend[6];
      res.tex_v       = s14_r.blend[7];
      res.faces_front = dot[49];
    end
  end

  // two-entry output buffer
  assign push      = adv && sv_r[NST];
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = ent0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && (cnt_r == 2'd0 || (pop && cnt_r == 2'd1))) ent0_r <= res;
    else if (pop)                                         ent0_r <= ent1_r;
    if (push && !pop && cnt_r == 2'd1) ent1_r <= res;
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.hit_dist == 0 && !out_data.faces_front)
    else $error("miss result carries nonzero fields");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push)
    else $error("result pushed into full output buffer");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv && sv_r[NST] |=> sv_r[NST])
    else $error("pending result lost during stall");

endmodule
